/* src/pulse_period_flow_meter_macros.svh */
// Assertion macros shared by the pulse period flow meter modules.
`ifndef PULSE_PERIOD_FLOW_METER_MACROS_SVH
`define PULSE_PERIOD_FLOW_METER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PPFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PPFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ppfm_pkg.sv */
// Shared constants, types and the flow numerator table of the pulse period flow meter.
package ppfm_pkg;

  localparam int CNT_W = 32;
  localparam int DAY_W = 3;
  localparam int FLOW_W = 26;
  localparam int TICK_W = 16;
  localparam int LIM_W = TICK_W + 2;
  localparam int EXP_W = 2;
  localparam int PUB_W = 4;
  localparam int EVT_W = 2;

  localparam int IN_FIELDS_W = CNT_W + DAY_W + 1;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * FLOW_W + 1 + EVT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int DIV_STEPS = FLOW_W;
  localparam int DIVCNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [TICK_W-1:0] MAX_TICKS = TICK_W'(36100);
  localparam logic [PUB_W-1:0] TICKS_PER_PUBLISH = PUB_W'(10);
  localparam logic [FLOW_W-1:0] FLOW_LIMIT = FLOW_W'(36000000);

  localparam logic [EVT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVT_W-1:0] EV_NEW_MAX = 2'd1;
  localparam logic [EVT_W-1:0] EV_CLEARED = 2'd2;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic finish;
  } ppfm_cmd_t;

  typedef struct packed {
    logic div_done;
  } ppfm_sts_t;

  function automatic logic [FLOW_W-1:0] flow_numerator(input logic [EXP_W-1:0] exp_code);
    logic [FLOW_W-1:0] num;
    case (exp_code)
      2'd0:    num = FLOW_W'(36000);
      2'd1:    num = FLOW_W'(360000);
      2'd2:    num = FLOW_W'(3600000);
      default: num = FLOW_W'(36000000);
    endcase
    return num;
  endfunction

endpackage

/* src/pulse_period_flow_meter.sv */
// Top level of the pulse period flow meter.
// Each input beat is one 100 ms tick: the cumulative pulse count, the weekday
// and a request to clear the recorded maximum. Each tick yields exactly one
// output beat with the current flow, the published flow, the peak, the sensor
// fault flag and an event code for software.
// The block works on one tick at a time. A tick that needs a flow division
// runs through the restoring divider, which retires one quotient bit per cycle
// over 26 bits; other ticks pass the divide state without a division step.
// The next tick is accepted as soon as the controller is back in idle.
// The output beat sits in a register, so a new tick may be accepted while the
// previous result still waits; if the receiver stalls, the block holds the
// finished result of the next tick until the register frees up.
// The pulse exponent register is written through cfg_wr_en and cfg_wr_data;
// the user must do so only while idle; the block does not enforce it. Reset
// is synchronous and restores all but the divider and output data registers.
module pulse_period_flow_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ppfm_pkg::EXP_W-1:0]       cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pulse_count, weekday, clear_max, zero fill.
  input  logic [ppfm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // flow_now, flow_published, flow_peak, sensor_fault, max_event, zero fill.
  output logic [ppfm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ppfm_pkg::*;

  ppfm_cmd_t        cmd;
  ppfm_sts_t        sts;
  logic [CNT_W-1:0] pulse_count;
  logic [DAY_W-1:0] weekday;
  logic             clear_max;

  assign pulse_count = in_tdata[CNT_W-1:0];
  assign weekday = in_tdata[CNT_W+DAY_W-1:CNT_W];
  assign clear_max = in_tdata[CNT_W+DAY_W];

  ppfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ppfm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pulse_count (pulse_count),
    .weekday     (weekday),
    .clear_max   (clear_max),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_tdata)
  );

endmodule

/* src/ppfm_ctrl.sv */
// Controller state machine that sequences accept, divide and result hand-off.
module ppfm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ppfm_pkg::ppfm_sts_t sts,
  output ppfm_pkg::ppfm_cmd_t cmd
);
  import ppfm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && (state_r == ST_IDLE);
    cmd.div_step = (state_r == ST_DIV);
    cmd.finish = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (cmd.finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "pulse_period_flow_meter_macros.svh"
  `PPFM_ASSERT_NOW(a_finish_slot_free, cmd.finish, !out_valid_r || out_tready, "finish with full output")
  `PPFM_ASSERT_NEXT(a_accept_to_div, cmd.accept, state_r == ST_DIV, "accept did not start divide")
  `PPFM_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r && state_r == ST_IDLE, "finish lost result")

endmodule

/* src/ppfm_dp.sv */
// Datapath holding the meter state, the serial divider and the result register.
module ppfm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ppfm_pkg::EXP_W-1:0]     cfg_wr_data,
  input  logic [ppfm_pkg::CNT_W-1:0]     pulse_count,
  input  logic [ppfm_pkg::DAY_W-1:0]     weekday,
  input  logic                           clear_max,
  input  ppfm_pkg::ppfm_cmd_t            cmd,
  output ppfm_pkg::ppfm_sts_t            sts,
  output logic [ppfm_pkg::OUT_TDATA_W-1:0] out_data
);
  import ppfm_pkg::*;

  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic                first_r, first_nxt;
  logic                armed_r, armed_nxt;
  logic [CNT_W-1:0]    last_count_r, last_count_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]   last_int_r, last_int_nxt;
  logic [FLOW_W-1:0]   flow_r, flow_nxt;
  logic [FLOW_W-1:0]   pub_r, pub_nxt;
  logic [FLOW_W-1:0]   peak_r, peak_nxt;
  logic                seen_r, seen_nxt;
  logic [DAY_W-1:0]    lastday_r, lastday_nxt;
  logic                fault_r, fault_nxt;
  logic [PUB_W-1:0]    pubdiv_r, pubdiv_nxt;
  logic [EVT_W-1:0]    event_r, event_nxt;
  logic                publish_r, publish_nxt;
  logic                need_div_r, need_div_nxt;
  logic [TICK_W-1:0]   divisor_r, divisor_nxt;
  logic [FLOW_W-1:0]   quot_r, quot_nxt;
  logic [TICK_W-1:0]   rem_r, rem_nxt;
  logic [DIVCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [OUT_FIELDS_W-1:0] out_r, out_nxt;

  logic [TICK_W-1:0] e1;
  logic [LIM_W-1:0]  lim3;
  logic [PUB_W-1:0]  p1;
  logic [TICK_W:0]   trial;
  logic              qbit;
  logic [FLOW_W-1:0] flow_fin;
  logic [EVT_W-1:0]  evt_fin;

  assign sts.div_done = (div_cnt_r == '0);
  assign out_data = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_r};

  always_comb begin
    e1 = (elapsed_r <= MAX_TICKS) ? elapsed_r + TICK_W'(1) : elapsed_r;
    lim3 = {2'b00, last_int_r} + {1'b0, last_int_r, 1'b0};
    p1 = pubdiv_r + PUB_W'(1);
    trial = {rem_r, quot_r[FLOW_W-1]};
    qbit = (trial >= {1'b0, divisor_r});
    flow_fin = need_div_r ? quot_r : flow_r;
  end

  always_comb begin
    exp_nxt = exp_r;
    first_nxt = first_r;
    armed_nxt = armed_r;
    last_count_nxt = last_count_r;
    elapsed_nxt = elapsed_r;
    last_int_nxt = last_int_r;
    flow_nxt = flow_r;
    pub_nxt = pub_r;
    peak_nxt = peak_r;
    seen_nxt = seen_r;
    lastday_nxt = lastday_r;
    fault_nxt = fault_r;
    pubdiv_nxt = pubdiv_r;
    event_nxt = event_r;
    publish_nxt = publish_r;
    need_div_nxt = need_div_r;
    divisor_nxt = divisor_r;
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    div_cnt_nxt = div_cnt_r;
    out_nxt = out_r;
    evt_fin = event_r;

    if (cfg_wr_en) exp_nxt = cfg_wr_data;

    if (cmd.accept) begin
      event_nxt = EV_NONE;
      publish_nxt = 1'b0;
      need_div_nxt = 1'b0;
      div_cnt_nxt = '0;
      if (first_r) begin
        last_count_nxt = pulse_count;
        elapsed_nxt = '0;
        first_nxt = 1'b0;
      end else if (clear_max) begin
        peak_nxt = '0;
        event_nxt = EV_CLEARED;
      end else begin
        lastday_nxt = weekday;
        if (lastday_r != '0 && lastday_r != weekday) begin
          if (seen_r) begin
            seen_nxt = 1'b0;
            fault_nxt = 1'b0;
          end else begin
            fault_nxt = 1'b1;
          end
        end
        elapsed_nxt = e1;
        if (pulse_count != last_count_r) begin
          if (armed_r) begin
            armed_nxt = 1'b0;
          end else begin
            seen_nxt = 1'b1;
            fault_nxt = 1'b0;
            need_div_nxt = 1'b1;
            last_int_nxt = e1;
            elapsed_nxt = '0;
            last_count_nxt = pulse_count;
          end
        end else if (e1 > last_int_r) begin
          if ({2'b00, e1} > lim3 || e1 >= MAX_TICKS) begin
            flow_nxt = '0;
          end else begin
            need_div_nxt = 1'b1;
          end
        end
        if (need_div_nxt) begin
          divisor_nxt = e1;
          quot_nxt = flow_numerator(exp_r);
          rem_nxt = '0;
          div_cnt_nxt = DIVCNT_W'(DIV_STEPS);
        end
        if (p1 >= TICKS_PER_PUBLISH) begin
          pubdiv_nxt = '0;
          publish_nxt = 1'b1;
        end else begin
          pubdiv_nxt = p1;
        end
      end
    end else if (cmd.div_step && div_cnt_r != '0) begin
      rem_nxt = qbit ? TICK_W'(trial - {1'b0, divisor_r}) : trial[TICK_W-1:0];
      quot_nxt = {quot_r[FLOW_W-2:0], qbit};
      div_cnt_nxt = div_cnt_r - DIVCNT_W'(1);
    end else if (cmd.finish) begin
      flow_nxt = flow_fin;
      need_div_nxt = 1'b0;
      if (publish_r) begin
        pub_nxt = flow_fin;
        if (flow_fin > peak_r) begin
          peak_nxt = flow_fin;
          evt_fin = EV_NEW_MAX;
        end
      end
      out_nxt = {evt_fin, fault_r, peak_nxt, pub_nxt, flow_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      first_r <= 1'b1;
      armed_r <= 1'b1;
      last_count_r <= '0;
      elapsed_r <= '0;
      last_int_r <= '0;
      flow_r <= '0;
      pub_r <= '0;
      peak_r <= '0;
      seen_r <= 1'b1;
      lastday_r <= '0;
      fault_r <= 1'b0;
      pubdiv_r <= '0;
      event_r <= EV_NONE;
      publish_r <= 1'b0;
      need_div_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      exp_r <= exp_nxt;
      first_r <= first_nxt;
      armed_r <= armed_nxt;
      last_count_r <= last_count_nxt;
      elapsed_r <= elapsed_nxt;
      last_int_r <= last_int_nxt;
      flow_r <= flow_nxt;
      pub_r <= pub_nxt;
      peak_r <= peak_nxt;
      seen_r <= seen_nxt;
      lastday_r <= lastday_nxt;
      fault_r <= fault_nxt;
      pubdiv_r <= pubdiv_nxt;
      event_r <= event_nxt;
      publish_r <= publish_nxt;
      need_div_r <= need_div_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

`include "pulse_period_flow_meter_macros.svh"
  `PPFM_ASSERT_NOW(a_divisor_nonzero, div_cnt_r != '0, divisor_r != '0, "divide by zero")
  `PPFM_ASSERT_NOW(a_div_cnt_range, 1'b1, div_cnt_r <= DIVCNT_W'(DIV_STEPS), "divide count overrun")
  `PPFM_ASSERT_NOW(a_flow_range, 1'b1, flow_r <= FLOW_LIMIT, "flow out of range")
  `PPFM_ASSERT_NEXT(a_peak_tracks, cmd.finish && publish_r, peak_r >= pub_r, "peak below published flow")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the pulse period flow meter: directed ticks, random tick streams, then a pulse-free stretch.
`timescale 1ns / 1ps

module tb_top;
  import ppfm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 150;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [DAY_W-1:0] day;
    logic             clr;
  } tick_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow_now;
    logic [FLOW_W-1:0] flow_pub;
    logic [FLOW_W-1:0] flow_peak;
    logic              fault;
    logic [EVT_W-1:0]  evt;
  } flow_rec_t;

  typedef struct packed {
    tick_t     tick;
    logic      typed;
    flow_rec_t want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [EXP_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  // pulse_count, weekday, clear_max, zero fill.
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // flow_now, flow_published, flow_peak, sensor_fault, max_event, zero fill.
  logic [OUT_TDATA_W-1:0] out_tdata;

  pulse_period_flow_meter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the meter state.
  logic [EXP_W-1:0] m_exp;
  logic             m_first;
  logic             m_armed;
  logic [CNT_W-1:0] m_last_count;
  int unsigned      m_elapsed;
  int unsigned      m_interval;
  int unsigned      m_flow;
  int unsigned      m_pub;
  int unsigned      m_peak;
  logic             m_pulse_seen;
  logic [DAY_W-1:0] m_last_day;
  logic             m_fault;
  int unsigned      m_div;

  flow_rec_t   pending_flow_q[$];
  dir_row_t    dir_tab[$];
  int          mismatch_cnt;
  int          stall_cycles;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  logic [CNT_W-1:0] gen_count;
  logic [DAY_W-1:0] gen_day;

  always #5 clk = ~clk;

  function automatic int unsigned flow_rate(int unsigned ticks);
    int unsigned litres;
    case (m_exp)
      2'd0:    litres = 1;
      2'd1:    litres = 10;
      2'd2:    litres = 100;
      default: litres = 1000;
    endcase
    if (ticks == 0) return 0;
    return ((litres * 36000) / ticks) & 32'h3FF_FFFF;
  endfunction

  function automatic flow_rec_t meter_snapshot(logic [EVT_W-1:0] evt);
    flow_rec_t r;
    r.flow_now  = m_flow[FLOW_W-1:0];
    r.flow_pub  = m_pub[FLOW_W-1:0];
    r.flow_peak = m_peak[FLOW_W-1:0];
    r.fault     = m_fault;
    r.evt       = evt;
    return r;
  endfunction

  function automatic flow_rec_t meter_step(tick_t t);
    logic [EVT_W-1:0] evt;
    evt = EV_NONE;
    if (m_first) begin
      m_last_count = t.count;
      m_elapsed = 0;
      m_first = 1'b0;
      return meter_snapshot(EV_NONE);
    end
    if (t.clr) begin
      m_peak = 0;
      return meter_snapshot(EV_CLEARED);
    end
    if (m_last_day == 0) m_last_day = t.day;
    if (m_last_day != t.day) begin
      m_last_day = t.day;
      if (m_pulse_seen) begin
        m_pulse_seen = 1'b0;
        m_fault = 1'b0;
      end else begin
        m_fault = 1'b1;
      end
    end
    if (m_elapsed <= 32'(MAX_TICKS)) m_elapsed = (m_elapsed + 1) & 32'hFFFF;
    if (t.count != m_last_count) begin
      if (m_armed) begin
        m_armed = 1'b0;
      end else begin
        m_pulse_seen = 1'b1;
        m_fault = 1'b0;
        m_flow = flow_rate(m_elapsed);
        m_interval = m_elapsed;
        m_elapsed = 0;
        m_last_count = t.count;
      end
    end else if (m_elapsed > m_interval) begin
      if (m_elapsed > m_interval * 3 || m_elapsed >= 32'(MAX_TICKS)) m_flow = 0;
      else m_flow = flow_rate(m_elapsed);
    end
    m_div = (m_div + 1) & 32'hF;
    if (m_div < 32'(TICKS_PER_PUBLISH)) return meter_snapshot(EV_NONE);
    m_div = 0;
    m_pub = m_flow;
    if (m_pub > m_peak) begin
      m_peak = m_pub;
      evt = EV_NEW_MAX;
    end
    return meter_snapshot(evt);
  endfunction

  function automatic dir_row_t row(logic [CNT_W-1:0] count, logic [DAY_W-1:0] day,
                                   logic clr);
    dir_row_t r;
    r = '0;
    r.tick.count = count;
    r.tick.day = day;
    r.tick.clr = clr;
    return r;
  endfunction

  task automatic send_tick(tick_t t, logic typed, flow_rec_t want);
    flow_rec_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({t.clr, t.day, t.count});
    do @(posedge clk); while (!in_tready);
    pred = meter_step(t);
    pending_flow_q.push_back(typed ? want : pred);
  endtask

  task automatic write_exponent(logic [EXP_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_flow_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_exp = value;
  endtask

  task automatic run_random(int n);
    tick_t t;
    int gap;
    int r;
    gap = 0;
    for (int i = 0; i < n; i++) begin
      t.clr = ($urandom_range(0, 99) < 2);
      if ($urandom_range(0, 99) < 4) begin
        t.count = $urandom;
        t.day = DAY_W'($urandom_range(0, 7));
      end else begin
        if (gap == 0) begin
          r = $urandom_range(0, 9);
          gap = (r < 3) ? $urandom_range(0, 2) :
                (r < 8) ? $urandom_range(3, 30) : $urandom_range(31, 120);
          gen_count = gen_count + (($urandom_range(0, 4) == 0) ? $urandom : 1);
        end else begin
          gap--;
        end
        if ($urandom_range(0, 99) < 3)
          gen_day = ($urandom_range(0, 9) == 0) ? 3'd0 : DAY_W'($urandom_range(1, 7));
        t.count = gen_count;
        t.day = gen_day;
      end
      send_tick(t, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    flow_rec_t got;
    flow_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.flow_now  = out_tdata[FLOW_W-1:0];
      got.flow_pub  = out_tdata[2*FLOW_W-1:FLOW_W];
      got.flow_peak = out_tdata[3*FLOW_W-1:2*FLOW_W];
      got.fault     = out_tdata[3*FLOW_W];
      got.evt       = out_tdata[3*FLOW_W+EVT_W:3*FLOW_W+1];
      if (pending_flow_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result beat at %0t.", $realtime);
      end else begin
        want = pending_flow_q.pop_front();
        if (got.flow_now !== want.flow_now || got.flow_pub !== want.flow_pub ||
            got.flow_peak !== want.flow_peak || got.fault !== want.fault ||
            got.evt !== want.evt) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Mismatch at %0t: expected now=%0d pub=%0d peak=%0d flt=%0d evt=%0d,",
                     $realtime, want.flow_now, want.flow_pub, want.flow_peak, want.fault,
                     want.evt);
            $display("  got now=%0d pub=%0d peak=%0d flt=%0d evt=%0d.",
                     got.flow_now, got.flow_pub, got.flow_peak, got.fault, got.evt);
          end
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tick_t t;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    snd_idle_pct = 15;
    rcv_idle_pct = 59;
    m_exp = '0;
    m_first = 1'b1;
    m_armed = 1'b1;
    m_last_count = '0;
    m_elapsed = 0;
    m_interval = 0;
    m_flow = 0;
    m_pub = 0;
    m_peak = 0;
    m_pulse_seen = 1'b1;
    m_last_day = '0;
    m_fault = 1'b0;
    m_div = 0;
    gen_count = $urandom;
    gen_day = 3'd1;

    // The first tick only latches the count; a clear request then skips the rest of the tick.
    dir_tab.push_back('{tick: '{32'hFFFF_FFFF, 3'd0, 1'b0}, typed: 1'b1,
                        want: '{'0, '0, '0, 1'b0, EV_NONE}});
    dir_tab.push_back('{tick: '{32'h0000_0000, 3'd5, 1'b1}, typed: 1'b1,
                        want: '{'0, '0, '0, 1'b0, EV_CLEARED}});
    dir_tab.push_back(row(32'hFFFF_FFFF, 3'd7, 1'b0));
    dir_tab.push_back(row(32'h0000_0000, 3'd7, 1'b0));
    dir_tab.push_back(row(32'h0000_0000, 3'd7, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 3'd1, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 3'd2, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 3'd3, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 3'd0, 1'b0));
    dir_tab.push_back(row(32'h0000_0001, 3'd4, 1'b0));
    dir_tab.push_back(row(32'h0000_0002, 3'd4, 1'b0));
    for (int i = 0; i < 5; i++) dir_tab.push_back(row(32'h0000_0002, 3'd4, 1'b0));
    dir_tab.push_back(row(32'h0000_0002, 3'd4, 1'b1));
    dir_tab.push_back(row(32'h0000_0003, 3'd4, 1'b0));
    dir_tab.push_back(row(32'h8000_0000, 3'd6, 1'b0));
    for (int i = 0; i < 4; i++) dir_tab.push_back(row(32'h8000_0000, 3'd6, 1'b0));
    dir_tab.push_back(row(32'h7FFF_FFFF, 3'd6, 1'b0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);

    write_exponent(2'd3);
    run_random(350);

    snd_idle_pct = 59;
    rcv_idle_pct = 15;
    write_exponent(2'd1);
    run_random(350);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_exponent(2'd2);
    run_random(300);

    write_exponent(2'd0);
    run_random(250);

    // A pulse-free stretch long enough for the flow to decay to zero.
    write_exponent(2'd3);
    t.clr = 1'b0;
    t.day = 3'd2;
    for (int i = 0; i < 3; i++) begin
      gen_count = gen_count + 1;
      t.count = gen_count;
      send_tick(t, 1'b0, '0);
    end
    for (int i = 0; i < LONG_HOLD; i++) send_tick(t, 1'b0, '0);
    for (int i = 0; i < 30; i++) begin
      if (i % 7 == 0) gen_count = gen_count + 1;
      t.count = gen_count;
      send_tick(t, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_flow_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && pending_flow_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
